>>> sv/mouse_packet_pointer_tracker_macros.svh
// Assertion macros used by the pointer tracker top level.
`ifndef MOUSE_PACKET_POINTER_TRACKER_MACROS_SVH
`define MOUSE_PACKET_POINTER_TRACKER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MPT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mouse tracker assertion failed");

// Next-cycle implication, checked outside reset.
`define MPT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mouse tracker assertion failed");

`endif

>>> sv/mpt_pkg.sv
// Types, constants and codes shared by the mouse pointer tracker.
package mpt_pkg;

  localparam int COORD_BITS = 13;
  localparam int CFG_W      = 14;
  localparam int CMP_W      = (CFG_W > COORD_BITS) ? CFG_W : COORD_BITS;
  localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(1024);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(768);

  // Register indexes on the configuration port.
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Item kinds.
  localparam logic KIND_BYTE     = 1'b0;
  localparam logic KIND_RECENTER = 1'b1;

  // Packet byte codes as reported on next_phase.
  localparam logic [1:0] PHASE_CODE_STATUS = 2'd0;
  localparam logic [1:0] PHASE_CODE_X      = 2'd1;
  localparam logic [1:0] PHASE_CODE_Y      = 2'd2;

  typedef enum logic [2:0] {
    PH_STATUS = 3'b001,
    PH_X      = 3'b010,
    PH_Y      = 3'b100
  } phase_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    logic       kind;
    logic       from_mouse_port;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [12:0] pointer_x;
    logic [12:0] pointer_y;
    logic [2:0]  buttons;
    logic [1:0]  next_phase;
    logic        byte_rejected;
  } out_item_t;

  // Per-axis limits and recenter points derived from the screen size.
  typedef struct packed {
    coord_t lim_x;
    coord_t lim_y;
    coord_t ctr_x;
    coord_t ctr_y;
  } limits_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] status_byte;
    coord_t     pos_x;
    coord_t     pos_y;
  } track_state_t;

endpackage

>>> sv/mpt_cfg_regs.sv
// Screen size registers, kept as precomputed clamp limits and center points.
module mpt_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [mpt_pkg::CFG_W-1:0]   cfg_data,
  output mpt_pkg::limits_t            limits
);
  import mpt_pkg::*;

  logic [CFG_W-1:0] size_m1;
  logic [CFG_W-1:0] size_half;
  coord_t           lim_new;
  coord_t           ctr_new;
  limits_t          limits_next;

  // A size of zero behaves as one; both values saturate at the coordinate range.
  always_comb begin
    size_m1   = (cfg_data == '0) ? '0 : cfg_data - CFG_W'(1);
    size_half = cfg_data >> 1;
    if (CMP_W'(size_m1) > CMP_W'(COORD_MAX)) begin
      lim_new = coord_t'(COORD_MAX);
    end else begin
      lim_new = coord_t'(size_m1);
    end
    if (CMP_W'(size_half) > CMP_W'(COORD_MAX)) begin
      ctr_new = coord_t'(COORD_MAX);
    end else begin
      ctr_new = coord_t'(size_half);
    end
  end

  always_comb begin
    limits_next = limits;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH: begin
          limits_next.lim_x = lim_new;
          limits_next.ctr_x = ctr_new;
        end
        REG_SCREEN_HEIGHT: begin
          limits_next.lim_y = lim_new;
          limits_next.ctr_y = ctr_new;
        end
        default: begin
          limits_next = limits;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.lim_x <= coord_t'(WIDTH_RESET - CFG_W'(1));
      limits.ctr_x <= coord_t'(WIDTH_RESET >> 1);
      limits.lim_y <= coord_t'(HEIGHT_RESET - CFG_W'(1));
      limits.ctr_y <= coord_t'(HEIGHT_RESET >> 1);
    end else begin
      limits <= limits_next;
    end
  end

endmodule

>>> sv/mpt_decoder.sv
// Packet byte decoder: next tracker state and result item for one input item.
module mpt_decoder (
  input  mpt_pkg::in_item_t     item,
  input  mpt_pkg::track_state_t cur,
  input  mpt_pkg::limits_t      limits,
  output mpt_pkg::track_state_t nxt,
  output mpt_pkg::out_item_t    result
);
  import mpt_pkg::*;

  localparam int NP_W = COORD_BITS + 2;

  logic               rejected;
  logic signed [9:0]  dx;
  logic signed [9:0]  dy;
  logic [1:0]         phase_code;

  function automatic coord_t move_clamped(input coord_t pos, input logic [9:0] delta,
                                          input coord_t lim);
    logic [NP_W-1:0] np;
    np = {2'b00, pos} + {{(NP_W-10){delta[9]}}, delta};
    if (np[NP_W-1]) begin
      return '0;
    end else if (np[NP_W-2:0] > {1'b0, lim}) begin
      return lim;
    end else begin
      return np[COORD_BITS-1:0];
    end
  endfunction

  // Status bits 4 and 5 are the ninth bits of the X and Y movements.
  // Y is negated so that a positive movement moves the pointer up the screen.
  assign dx = {cur.status_byte[4], cur.status_byte[4], item.data_byte};
  assign dy = -$signed({cur.status_byte[5], cur.status_byte[5], item.data_byte});

  always_comb begin
    nxt      = cur;
    rejected = 1'b0;
    if (item.kind == KIND_RECENTER) begin
      nxt.pos_x = limits.ctr_x;
      nxt.pos_y = limits.ctr_y;
      nxt.phase = PH_STATUS;
    end else if (item.from_mouse_port) begin
      unique case (cur.phase)
        PH_X: begin
          nxt.pos_x = move_clamped(cur.pos_x, dx, limits.lim_x);
          nxt.phase = PH_Y;
        end
        PH_Y: begin
          nxt.pos_y = move_clamped(cur.pos_y, dy, limits.lim_y);
          nxt.phase = PH_STATUS;
        end
        default: begin
          // A status byte needs its always-one bit and no overflow bits.
          if (!item.data_byte[3] || (item.data_byte[7:6] != 2'b00)) begin
            rejected  = 1'b1;
            nxt.phase = PH_STATUS;
          end else begin
            nxt.status_byte = item.data_byte;
            nxt.phase       = PH_X;
          end
        end
      endcase
    end
  end

  always_comb begin
    unique case (nxt.phase)
      PH_X:    phase_code = PHASE_CODE_X;
      PH_Y:    phase_code = PHASE_CODE_Y;
      default: phase_code = PHASE_CODE_STATUS;
    endcase
  end

  always_comb begin
    result.pointer_x     = 13'(nxt.pos_x);
    result.pointer_y     = 13'(nxt.pos_y);
    result.buttons       = nxt.status_byte[2:0];
    result.next_phase    = phase_code;
    result.byte_rejected = rejected;
  end

endmodule

>>> sv/mouse_packet_pointer_tracker.sv
// Top level of the mouse packet pointer tracker: input register, state and result register.
// Takes mouse packet bytes one item per transfer and returns one result per item.
// An item is held in the input register and is then decoded into the result
// register, so a new item is taken every cycle while the result side keeps up;
// the only loop is the tracker state, which is updated in the same edge that
// captures the result. Screen size writes take effect on the next cycle and
// must be made while no item is in flight.
`include "mouse_packet_pointer_tracker_macros.svh"

module mouse_packet_pointer_tracker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  mpt_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mpt_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [mpt_pkg::CFG_W-1:0] cfg_data
);
  import mpt_pkg::*;

  limits_t      limits;
  logic         s1_valid;
  in_item_t     s1_item;
  logic         s1_adv;
  track_state_t state;
  track_state_t state_next;
  out_item_t    result;

  mpt_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .limits   (limits)
  );

  mpt_decoder u_dec (
    .item  (s1_item),
    .cur   (state),
    .limits(limits),
    .nxt   (state_next),
    .result(result)
  );

  // The held item moves on whenever the result register is empty or being drained.
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_STATUS;
      state.status_byte <= '0;
      state.pos_x       <= '0;
      state.pos_y       <= '0;
    end else if (s1_adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_item <= result;
    end
  end

  `MPT_ASSERT_SAME(a_stall_only_on_full, !in_ready, s1_valid && out_valid && !out_ready)
  `MPT_ASSERT_NEXT(a_adv_fills_output, s1_adv, out_valid)
  `MPT_ASSERT_SAME(a_reject_restarts_packet, out_valid && out_item.byte_rejected,
                   out_item.next_phase == PHASE_CODE_STATUS)
  `MPT_ASSERT_SAME(a_phase_code_valid, out_valid, out_item.next_phase != 2'd3)

endmodule
